FILE: hw/rtl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// shared types and fixed field widths of the huffman code builder
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int SYM_W     = 8;
    localparam int FREQ_IN_W = 20;
    localparam int CODE_W    = 63;
    localparam int LEN_W     = 6;

    typedef enum logic [2:0] {
        S_CLR,
        S_LOAD,
        S_BCHK,
        S_SCAN,
        S_PICK,
        S_ERD,
        S_EEV,
        S_POP
    } t_state;

endpackage

FILE: hw/rtl/huffman_code_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_builder
// collects symbol/frequency pairs, builds a huffman tree in memory and
// streams out every symbol with its code word in left-first preorder
// ----------------------------------------------------------------------------
// operation: symbols load, then the build runs 2*(n-1) scans of the nodes so far,
//   each followed by a pick, with one check per merge; the walk then visits parents and leaves
// throughput: one symbol per cycle while loading, save while the closing symbol
//   finishes its lookup; one set at a time
// reset: synchronous active-low; a clearing pass wipes the seen memory after
//   reset and after every 255th set, with the input stalled meanwhile
module huffman_code_builder
    import hcb_pkg::*;
#(
    parameter int MAX_SYMBOLS = 64,
    parameter int FREQ_BITS   = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [SYM_W-1:0]     i_symbol,
    input  logic [FREQ_IN_W-1:0] i_frequency,
    input  logic                 i_last_symbol,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [SYM_W-1:0]     o_out_symbol,
    output logic [CODE_W-1:0]    o_code_bits,
    output logic [LEN_W-1:0]     o_code_length,
    output logic                 o_last_code
);

    localparam int NODES     = 2 * MAX_SYMBOLS - 1;
    localparam int NODE_BITS = $clog2(NODES);
    localparam int LEAF_BITS = $clog2(MAX_SYMBOLS);
    localparam int CNT_BITS  = $clog2(MAX_SYMBOLS + 1);
    localparam int WT_BITS   = FREQ_BITS + $clog2(MAX_SYMBOLS);
    localparam int STK_W     = NODE_BITS + CODE_W + LEN_W;
    localparam int EP_W      = 8;

    // memories: leaf symbols, node weights with live flag on top, parent
    // children, walk stack, per-symbol epoch of the set that stored it
    logic [SYM_W-1:0]       m_leaf  [MAX_SYMBOLS];
    logic [WT_BITS:0]       m_wt    [NODES];
    logic [2*NODE_BITS-1:0] m_child [MAX_SYMBOLS-1];
    logic [STK_W-1:0]       m_stk   [MAX_SYMBOLS];
    logic [EP_W-1:0]        m_seen  [2**SYM_W];

    logic [SYM_W-1:0]       r_leaf_rd;
    logic [WT_BITS:0]       r_wt_rd;
    logic [2*NODE_BITS-1:0] r_child_rd;
    logic [STK_W-1:0]       r_stk_rd;
    logic [EP_W-1:0]        r_seen_rd;

    t_state r_state, n_state;

    // set counters and seen-memory epoch
    logic [CNT_BITS-1:0]    r_scount;
    logic [NODE_BITS-1:0]   r_ncount;
    logic [CNT_BITS-1:0]    r_live_cnt;
    logic [EP_W-1:0]        r_epoch;
    logic [SYM_W-1:0]       r_clr_idx;

    // accepted transaction waiting for its seen lookup
    logic                   r_p_vld;
    logic                   r_p_hit;
    logic [SYM_W-1:0]       r_p_sym;
    logic [WT_BITS-1:0]     r_p_freq;
    logic                   r_p_last;

    // lightest-node scan
    logic [NODE_BITS-1:0]   r_scan_idx;
    logic [NODE_BITS-1:0]   r_cmp_idx;
    logic                   r_cmp_vld;
    logic                   r_best_vld;
    logic [NODE_BITS-1:0]   r_best_idx;
    logic [WT_BITS-1:0]     r_best_w;
    logic                   r_pass;
    logic                   r_kill;
    logic [NODE_BITS-1:0]   r_a_idx;
    logic [WT_BITS-1:0]     r_a_w;

    // preorder walk
    logic [NODE_BITS-1:0]   r_node;
    logic [CODE_W-1:0]      r_code;
    logic [LEN_W-1:0]       r_len;
    logic [LEAF_BITS-1:0]   r_sp;

    // output register
    logic                   r_out_valid;
    logic [SYM_W-1:0]       r_o_symbol;
    logic [CODE_W-1:0]      r_o_code;
    logic [LEN_W-1:0]       r_o_len;
    logic                   r_o_last;

    logic                   w_accept, w_new, w_seen, w_close, w_cmp_take, w_is_leaf;
    logic [CNT_BITS-1:0]    w_cnt_next;
    logic [31:0]            w_freq32;
    logic [WT_BITS-1:0]     w_freq;
    logic                   w_ld_out, w_done, w_push, w_pop, w_scan_init, w_pick, w_root;
    logic [NODE_BITS-1:0]   w_left, w_right;

    // input side: a transaction is taken only while loading, and not in the
    // cycle where the closing transaction finishes its lookup
    assign w_close    = r_p_vld && r_p_last;
    assign o_stall    = (r_state != S_LOAD) || w_close;
    assign w_accept   = i_valid && !o_stall;
    assign w_freq32   = 32'(i_frequency);
    assign w_freq     = WT_BITS'(w_freq32[FREQ_BITS-1:0]);

    // seen in this set: epoch match, or the transaction just before stored it
    assign w_seen     = (r_seen_rd == r_epoch) || r_p_hit;
    assign w_new      = r_p_vld && !w_seen
                        && (r_scount != CNT_BITS'(MAX_SYMBOLS));
    assign w_cnt_next = r_scount + CNT_BITS'(w_new);

    // strict less-than keeps the lower index on equal weights
    assign w_cmp_take = r_cmp_vld && r_wt_rd[WT_BITS]
                        && (!r_best_vld || (r_wt_rd[WT_BITS-1:0] < r_best_w));
    assign w_is_leaf  = r_node < NODE_BITS'(r_scount);
    assign w_left     = r_child_rd[2*NODE_BITS-1:NODE_BITS];
    assign w_right    = r_child_rd[NODE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_ld_out    = 1'b0;
        w_done      = 1'b0;
        w_push      = 1'b0;
        w_pop       = 1'b0;
        w_scan_init = 1'b0;
        w_pick      = 1'b0;
        w_root      = 1'b0;
        case (r_state)
            S_CLR: begin
                if (r_clr_idx == '1) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (w_close) n_state = S_BCHK;
            end
            S_BCHK: begin
                // keep merging while more than one node is live
                if (r_live_cnt > CNT_BITS'(1)) begin
                    w_scan_init = 1'b1;
                    n_state     = S_SCAN;
                end else begin
                    w_root  = 1'b1;
                    n_state = S_ERD;
                end
            end
            S_SCAN: begin
                if (r_scan_idx == r_ncount && !r_cmp_vld) n_state = S_PICK;
            end
            S_PICK: begin
                w_pick  = 1'b1;
                n_state = r_pass ? S_BCHK : S_SCAN;
            end
            S_ERD: begin
                n_state = S_EEV;
            end
            S_EEV: begin
                if (w_is_leaf) begin
                    if (!r_out_valid || !i_stall) begin
                        w_ld_out = 1'b1;
                        if (r_sp == '0) begin
                            w_done  = 1'b1;
                            // epoch about to wrap: wipe the seen memory first
                            n_state = (r_epoch == '1) ? S_CLR : S_LOAD;
                        end else begin
                            w_pop   = 1'b1;
                            n_state = S_POP;
                        end
                    end
                end else begin
                    // right child goes on the stack, walk continues left
                    w_push  = 1'b1;
                    n_state = S_ERD;
                end
            end
            S_POP: begin
                n_state = S_ERD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            m_seen[r_clr_idx] <= '0;
        end else if (w_new) begin
            m_seen[r_p_sym] <= r_epoch;
        end
        r_seen_rd <= m_seen[i_symbol];
    end

    always_ff @(posedge i_clk) begin
        if (w_new) m_leaf[r_scount[LEAF_BITS-1:0]] <= r_p_sym;
        r_leaf_rd <= m_leaf[r_node[LEAF_BITS-1:0]];
    end

    // first pick retires its node at once, second pick writes the parent
    // and retires its node in the following check cycle
    always_ff @(posedge i_clk) begin
        if (w_new) begin
            m_wt[NODE_BITS'(r_scount)] <= {1'b1, r_p_freq};
        end else if (w_pick && !r_pass) begin
            m_wt[r_best_idx] <= {1'b0, r_best_w};
        end else if (w_pick && r_pass) begin
            m_wt[r_ncount] <= {1'b1, r_a_w + r_best_w};
        end else if (r_kill) begin
            m_wt[r_best_idx] <= {1'b0, r_best_w};
        end
        r_wt_rd <= m_wt[r_scan_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_pick && r_pass) begin
            m_child[LEAF_BITS'(r_ncount - NODE_BITS'(r_scount))] <= {r_a_idx, r_best_idx};
        end
        r_child_rd <= m_child[LEAF_BITS'(r_node - NODE_BITS'(r_scount))];
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            m_stk[r_sp] <= {w_right, {r_code[CODE_W-2:0], 1'b1}, r_len + LEN_W'(1)};
        end
        r_stk_rd <= m_stk[r_sp - LEAF_BITS'(1)];
    end

    // lookup stage of the input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_p_hit <= 1'b0;
        end else begin
            r_p_vld <= w_accept;
            r_p_hit <= w_accept && w_new && (i_symbol == r_p_sym);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_sym  <= i_symbol;
            r_p_freq <= w_freq;
            r_p_last <= i_last_symbol;
        end
    end

    // clearing pass index and set epoch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_epoch   <= EP_W'(1);
        end else begin
            if (r_state == S_CLR) r_clr_idx <= r_clr_idx + SYM_W'(1);
            if (w_done) r_epoch <= (r_epoch == '1) ? EP_W'(1) : r_epoch + EP_W'(1);
        end
    end

    // per-set counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_done) begin
            r_scount <= '0;
            r_ncount <= '0;
        end else if (w_new) begin
            r_scount <= w_cnt_next;
            r_ncount <= NODE_BITS'(w_cnt_next);
        end else if (w_pick && r_pass) begin
            r_ncount <= r_ncount + NODE_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_close) begin
            r_live_cnt <= w_cnt_next;
        end else if (w_pick && r_pass) begin
            r_live_cnt <= r_live_cnt - CNT_BITS'(1);
        end
    end

    // scan: address issued one cycle, weight compared the next
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld  <= 1'b0;
            r_best_vld <= 1'b0;
            r_pass     <= 1'b0;
            r_kill     <= 1'b0;
        end else begin
            r_kill <= w_pick && r_pass;
            if (w_scan_init || (w_pick && !r_pass)) begin
                r_scan_idx <= '0;
                r_cmp_vld  <= 1'b0;
                r_best_vld <= 1'b0;
            end else if (r_state == S_SCAN) begin
                if (r_scan_idx != r_ncount) begin
                    r_scan_idx <= r_scan_idx + NODE_BITS'(1);
                    r_cmp_idx  <= r_scan_idx;
                    r_cmp_vld  <= 1'b1;
                end else begin
                    r_cmp_vld <= 1'b0;
                end
                if (w_cmp_take) begin
                    r_best_vld <= 1'b1;
                    r_best_idx <= r_cmp_idx;
                    r_best_w   <= r_wt_rd[WT_BITS-1:0];
                end
            end
            if (w_scan_init) begin
                r_pass <= 1'b0;
            end else if (w_pick) begin
                r_pass <= !r_pass;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pick && !r_pass) begin
            r_a_idx <= r_best_idx;
            r_a_w   <= r_best_w;
        end
    end

    // preorder walk state
    always_ff @(posedge i_clk) begin
        if (w_root) begin
            r_node <= r_ncount - NODE_BITS'(1);
            r_code <= '0;
            r_len  <= '0;
            r_sp   <= '0;
        end else if (w_push) begin
            r_node <= w_left;
            r_code <= {r_code[CODE_W-2:0], 1'b0};
            r_len  <= r_len + LEN_W'(1);
            r_sp   <= r_sp + LEAF_BITS'(1);
        end else if (w_pop) begin
            r_sp <= r_sp - LEAF_BITS'(1);
        end else if (r_state == S_POP) begin
            {r_node, r_code, r_len} <= r_stk_rd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ld_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_out) begin
            r_o_symbol <= r_leaf_rd;
            r_o_code   <= r_code;
            r_o_len    <= r_len;
            r_o_last   <= (r_sp == '0);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_symbol  = r_o_symbol;
    assign o_code_bits   = r_o_code;
    assign o_code_length = r_o_len;
    assign o_last_code   = r_o_last;

endmodule

FILE: hw/rtl/hcb_checker.sv
// ----------------------------------------------------------------------------
// hcb_checker
// port-level checks for the huffman code builder
// ----------------------------------------------------------------------------
module hcb_checker
    import hcb_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic [SYM_W-1:0]     i_symbol,
    input logic [FREQ_IN_W-1:0] i_frequency,
    input logic                 i_last_symbol,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [SYM_W-1:0]     o_out_symbol,
    input logic [CODE_W-1:0]    o_code_bits,
    input logic [LEN_W-1:0]     o_code_length,
    input logic                 o_last_code
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_symbol)
        && $stable(o_code_bits) && $stable(o_code_length) && $stable(o_last_code))
        else $error("output changed while stalled");

    // closing the set stops input intake
    a_close_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last_symbol |=> o_stall)
        else $error("input taken after last symbol");

    // no code bits above the code length
    a_code_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_code_bits >> o_code_length) == '0))
        else $error("code bits beyond length");

    // a lone leaf root has no code; otherwise length is at least one
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_code_length == '0) |-> o_last_code)
        else $error("empty code not alone");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (.*);

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the huffman code builder: drives symbol sets with
// random gaps and back-pressure, predicts every code word from its own tree
// build and compares each output transaction field by field
// ----------------------------------------------------------------------------
module tb_top;
    import hcb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SYM   = 64;
    localparam int N_NODE  = 2 * N_SYM - 1;
    localparam int RUN_CAP = 3000000;

    typedef struct {
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_code_word;

    // expected code words plus a private copy of the tree under construction
    class code_scoreboard;
        t_code_word     pending_codes[$];
        logic [7:0]     leaf_sym[N_SYM];
        longint         weight[N_NODE];
        int             left_of[N_NODE];
        int             right_of[N_NODE];
        bit             live[N_NODE];
        int             n_leaves;
        int             n_nodes;
        int             errors;
        int             codes_seen;
        int             sets_closed;

        function new();
            errors = 0;
            codes_seen = 0;
            sets_closed = 0;
            clear_set();
        endfunction

        function void clear_set();
            n_leaves = 0;
            n_nodes = 0;
            foreach (live[i]) live[i] = 0;
        endfunction

        // lightest live node, lower index wins on equal weight
        function int lightest();
            int best;
            best = -1;
            for (int i = 0; i < n_nodes; i++)
                if (live[i] && (best < 0 || weight[i] < weight[best]))
                    best = i;
            return best;
        endfunction

        function void build_and_emit();
            int          remaining, a, b, sp;
            int          stk_node[2*N_SYM+2];
            logic [63:0] stk_code[2*N_SYM+2];
            int          stk_len[2*N_SYM+2];
            int          nd, first_idx;
            t_code_word  cw;
            remaining = n_leaves;
            first_idx = pending_codes.size();
            while (remaining > 1) begin
                a = lightest();
                live[a] = 0;
                b = lightest();
                live[b] = 0;
                weight[n_nodes] = weight[a] + weight[b];
                left_of[n_nodes] = a;
                right_of[n_nodes] = b;
                live[n_nodes] = 1;
                n_nodes++;
                remaining--;
            end
            if (n_leaves > 0) begin
                // preorder walk, left child pushed last so it pops first
                stk_node[0] = n_nodes - 1;
                stk_code[0] = 0;
                stk_len[0] = 0;
                sp = 1;
                while (sp > 0) begin
                    sp--;
                    nd = stk_node[sp];
                    if (nd < n_leaves) begin
                        cw.sym = leaf_sym[nd];
                        cw.bits = stk_code[sp][CODE_W-1:0];
                        cw.len = stk_len[sp][LEN_W-1:0];
                        cw.last = 0;
                        pending_codes.push_back(cw);
                    end else begin
                        stk_node[sp] = right_of[nd];
                        stk_code[sp] = (stk_code[sp] << 1) | 64'd1;
                        stk_len[sp+1] = stk_len[sp] + 1;
                        stk_len[sp] = stk_len[sp+1];
                        stk_node[sp+1] = left_of[nd];
                        stk_code[sp+1] = stk_code[sp] & ~64'd1;
                        sp += 2;
                    end
                end
                pending_codes[pending_codes.size()-1].last = 1;
            end
            if (pending_codes.size() < first_idx) $display("internal queue error");
            sets_closed++;
            clear_set();
        endfunction

        // accepted input transaction
        function void note_symbol(logic [7:0] sym, logic [19:0] freq, logic last);
            bit seen;
            seen = 0;
            for (int i = 0; i < n_leaves; i++)
                if (leaf_sym[i] == sym) seen = 1;
            if (!seen && n_leaves < N_SYM) begin
                leaf_sym[n_leaves] = sym;
                weight[n_leaves] = freq;
                live[n_leaves] = 1;
                n_leaves++;
                n_nodes = n_leaves;
            end
            if (last) build_and_emit();
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch on code word %0d: %s got %0h expected %0h",
                     codes_seen, what, got, want);
            errors++;
        endtask

        // accepted output transaction
        task check_code(logic [7:0] sym, logic [CODE_W-1:0] bits,
                        logic [LEN_W-1:0] len, logic last);
            t_code_word w;
            if (pending_codes.size() == 0) begin
                report_mismatch("unexpected symbol", sym, 64'd0);
            end else begin
                w = pending_codes.pop_front();
                if (sym !== w.sym) report_mismatch("symbol", sym, w.sym);
                if (bits !== w.bits) report_mismatch("code", bits, w.bits);
                if (len !== w.len) report_mismatch("length", len, w.len);
                if (last !== w.last) report_mismatch("last", last, w.last);
            end
            codes_seen++;
        endtask
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_valid = 0;
    logic                 o_stall;
    logic [SYM_W-1:0]     i_symbol = 0;
    logic [FREQ_IN_W-1:0] i_frequency = 0;
    logic                 i_last_symbol = 0;
    logic                 o_valid;
    logic                 i_stall = 0;
    logic [SYM_W-1:0]     o_out_symbol;
    logic [CODE_W-1:0]    o_code_bits;
    logic [LEN_W-1:0]     o_code_length;
    logic                 o_last_code;

    code_scoreboard sb = new();
    int  src_idle_pct = 0;
    int  sink_idle_pct = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    int  perm[256];

    huffman_code_builder u_top (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // run limit, far above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk)
        i_stall <= ($urandom_range(0, 99) < sink_idle_pct);

    // output monitor
    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall)
            sb.check_code(o_out_symbol, o_code_bits, o_code_length, o_last_code);

    // one input transaction, with random idle cycles ahead of it
    task automatic send_symbol(logic [7:0] sym, logic [19:0] freq, logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_symbol <= sym;
        i_frequency <= freq;
        i_last_symbol <= last;
        do @(posedge i_clk); while (o_stall);
        sb.note_symbol(sym, freq, last);
        items_sent++;
    endtask

    // random set: distinct symbols from a shuffle, some repeats mixed in
    // freq_mode 0 full range, 1 tiny weights for many ties, 2 mixed
    task automatic send_set(int n, int rep_pct, int freq_mode);
        logic [19:0] f;
        int          sym, j, t;
        for (int i = 0; i < 256; i++) perm[i] = i;
        for (int i = 0; i < 255; i++) begin
            j = $urandom_range(i, 255);
            t = perm[i]; perm[i] = perm[j]; perm[j] = t;
        end
        for (int k = 0; k < n; k++) begin
            if (k > 0 && $urandom_range(0, 99) < rep_pct)
                sym = perm[$urandom_range(0, k-1)];
            else
                sym = perm[k];
            case (freq_mode)
                0: f = 20'($urandom_range(0, 20'hFFFFF));
                1: f = 20'($urandom_range(0, 7));
                default: f = $urandom_range(0, 1) ? 20'($urandom_range(0, 20'hFFFFF))
                                                   : 20'($urandom_range(0, 3));
            endcase
            send_symbol(sym[7:0], f, k == n - 1);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: lone symbol gets an empty code
        send_symbol(8'hFF, 20'h00010, 1);
        // two symbols at the frequency extremes
        send_symbol(8'h00, 20'hFFFFF, 0);
        send_symbol(8'hFF, 20'h00000, 1);
        // four equal weights, ties go to the lower node index
        send_symbol(8'h11, 20'd5, 0);
        send_symbol(8'h22, 20'd5, 0);
        send_symbol(8'h33, 20'd5, 0);
        send_symbol(8'h44, 20'd5, 1);
        // repeated symbol keeps its first frequency
        send_symbol(8'h05, 20'd9, 0);
        send_symbol(8'h03, 20'd1, 0);
        send_symbol(8'h05, 20'd0, 0);
        send_symbol(8'hA5, 20'd2, 1);
        // closing item is a repeat and still closes the set
        send_symbol(8'h80, 20'd3, 0);
        send_symbol(8'h7F, 20'd4, 0);
        send_symbol(8'h80, 20'd100, 1);
        // every frequency bit high and low across a few symbols
        send_symbol(8'h55, 20'hAAAAA, 0);
        send_symbol(8'hAA, 20'h55555, 0);
        send_symbol(8'h01, 20'hFFFFF, 1);

        // phase one: sender idles a little, receiver a lot; full table
        // overflow with a closing item that is dropped
        src_idle_pct = 21;
        sink_idle_pct = 85;
        send_set(66, 0, 2);
        while (items_sent < 140) send_set($urandom_range(1, 9), 20, $urandom_range(0, 2));

        // phase two: the other way round
        src_idle_pct = 85;
        sink_idle_pct = 21;
        while (items_sent < 190) send_set($urandom_range(1, 9), 20, $urandom_range(0, 2));

        // phase three: no idling, one exactly full set
        src_idle_pct = 0;
        sink_idle_pct = 0;
        send_set(64, 0, 1);
        while (items_sent < 260) send_set($urandom_range(1, 12), 15, $urandom_range(0, 2));
        i_valid <= 0;

        while (sb.pending_codes.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("%0d symbols in %0d sets, %0d code words checked, %0d errors",
                 items_sent, sb.sets_closed, sb.codes_seen, sb.errors);
        $display("covered lone symbols, ties, repeats, full table and both stall mixes");
        if (sb.errors == 0 && sb.pending_codes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
